// File: rtl/cpsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsi_pkg
// Shared types and constants of the circular peak search with parabolic
// interpolation: controller states, result field widths and result packing.
// ----------------------------------------------------------------------------
package cpsi_pkg;

  // Configuration register
  localparam int CFG_W = 32;

  // Result fields
  localparam int LAG_W  = 8;
  localparam int FRAC_W = 9;
  localparam int PWR_W  = 32;
  localparam int DT_W   = 48;

  localparam int LAG_LSB  = 0;
  localparam int FRAC_LSB = LAG_LSB + LAG_W;
  localparam int PWR_LSB  = FRAC_LSB + FRAC_W;
  localparam int DT_LSB   = PWR_LSB + PWR_W;
  localparam int OUT_BITS = DT_LSB + DT_W;
  localparam int OUT_TDW  = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_TDW - OUT_BITS;

  // Power saturation limit, one bit wider than the power field
  localparam logic [PWR_W:0] PWR_MAX = {1'b0, {PWR_W{1'b1}}};

  // Signed 48-bit limits of delta_t
  localparam logic signed [DT_W-1:0] DT_MAX = {1'b0, {(DT_W-1){1'b1}}};
  localparam logic signed [DT_W-1:0] DT_MIN = {1'b1, {(DT_W-1){1'b0}}};

  // Fractional offset in Q.8, clamped to plus or minus one half
  localparam int FRAC_STEPS = 7;
  localparam logic signed [FRAC_W-1:0] FRAC_HALF = 9'sd128;

  // Steps of the bit-serial time scale multiply
  localparam int MUL_STEPS = CFG_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQR  = 9'b000000010,
    S_UPD  = 9'b000000100,
    S_FIN  = 9'b000001000,
    S_CMP  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_FINE = 9'b001000000,
    S_MUL  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

endpackage

// File: rtl/circular_peak_search_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_peak_search_interp
// Peak search over one circular impulse-response window with parabolic
// refinement of the peak lag, built from bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one complex sample per transaction, lag -WINDOW_HALF first;
//   tlast marks the final sample of the window and triggers one result on
//   m_axis. Samples past 2*WINDOW_HALF before tlast are ignored.
//   cfg carries time_scale; write it only while the block is idle.
// Samples are worked on one at a time: s_axis_tready stays low until the
//   power of the taken sample is formed and the window state updated. The power
//   is formed by a shift-and-add squarer that takes one multiplier bit per cycle.
// Result path after tlast: FIN, CMP, 7 restoring quotient steps when the
//   interpolation division runs, FINE, 32 bit-serial time_scale multiply steps, OUT.
// Reset clears the window state and the output valid; time_scale returns to 1.
// A stalled receiver holds the result in the output register; the block keeps
//   taking samples and waits only when a second result is ready to load.
// ----------------------------------------------------------------------------
module circular_peak_search_interp #(
  parameter int WINDOW_HALF = 80,
  parameter int SEARCH_HALF = 72,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [SAMPLE_BITS-1:0] sample_re, [2*SAMPLE_BITS-1:SAMPLE_BITS] sample_im, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tlast,   // last_sample
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] peak_lag, [16:8] frac_offset, [48:17] peak_power, [96:49] delta_t, zero pad
  output logic [cpsi_pkg::OUT_TDW-1:0]         m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cpsi_pkg::CFG_W-1:0]           cfg_data        // time_scale
);
  import cpsi_pkg::*;

  localparam int SB      = SAMPLE_BITS;
  localparam int SQW     = 2 * SB;
  localparam int WIN_LEN = 2 * WINDOW_HALF;
  localparam int REG_LO  = (WINDOW_HALF > SEARCH_HALF) ? WINDOW_HALF - SEARCH_HALF : 0;
  localparam int REG_HI  = (SEARCH_HALF < WINDOW_HALF) ? WINDOW_HALF + SEARCH_HALF : WIN_LEN;
  localparam int POSW    = $clog2(WIN_LEN + 1);
  localparam int LAGW    = POSW + 1;
  localparam int FINEW   = LAGW + 9;
  localparam int MACCW   = FINEW + 1 + CFG_W;
  localparam int XW      = (MACCW > DT_W) ? MACCW : DT_W;
  localparam int SATW    = (SQW > PWR_W) ? SQW : PWR_W + 1;
  localparam int MAXC    = (SB > MUL_STEPS) ? SB : MUL_STEPS;
  localparam int CNTW    = $clog2(MAXC);

  state_t state;
  logic [CNTW-1:0] cnt;
  logic [CFG_W-1:0] time_scale;

  // squarer
  logic [SB-1:0]  mplr_re, mplr_im;
  logic [SQW-1:0] mcand_re, mcand_im, sq_acc;
  logic           last_q;

  // window state
  logic [POSW-1:0]  position, best_position;
  logic [PWR_W-1:0] best_power, pwr_before, pwr_after, prev_power;
  logic             capture_next, found_any;

  // result path
  logic signed [LAGW-1:0]   lag_q;
  logic [PWR_W-1:0]         peak_q;
  logic                     interp_q, neg_q;
  logic [PWR_W-1:0]         div_a;
  logic [PWR_W+1:0]         div_d;
  logic [PWR_W+2:0]         div_r;
  logic [FRAC_STEPS-1:0]    div_q;
  logic signed [FRAC_W-1:0] frac_q;
  logic signed [MACCW-1:0]  mul_mcand, mul_acc;
  logic [CFG_W-1:0]         ts_sh;

  // combinational helpers
  logic signed [SB-1:0]     in_re, in_im;
  logic [SB-1:0]            mag_re, mag_im;
  logic [SQW-1:0]           sq_next;
  logic [SATW-1:0]          sq_ext;
  logic [PWR_W-1:0]         pw;
  logic                     in_reg, take_peak, interp_ok;
  logic signed [PWR_W:0]    diff;
  logic signed [PWR_W+2:0]  denom;
  logic [PWR_W+2:0]         div_r2;
  logic                     div_ge;
  logic [FRAC_STEPS-1:0]    div_q_next;
  logic signed [FINEW-1:0]  fine;
  logic signed [FINEW:0]    neg_fine;
  logic signed [MACCW-1:0]  mul_next;
  logic signed [XW-1:0]     mul_ext;
  logic signed [DT_W-1:0]   dt;
  logic                     out_load;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  always_comb begin
    in_re  = s_axis_tdata[SB-1:0];
    in_im  = s_axis_tdata[2*SB-1:SB];
    mag_re = in_re[SB-1] ? SB'(-in_re) : SB'(in_re);
    mag_im = in_im[SB-1] ? SB'(-in_im) : SB'(in_im);

    sq_next = sq_acc + (mplr_re[0] ? mcand_re : '0) + (mplr_im[0] ? mcand_im : '0);
    sq_ext  = SATW'(sq_acc);
    pw      = (sq_ext > SATW'(PWR_MAX)) ? {PWR_W{1'b1}} : sq_ext[PWR_W-1:0];

    in_reg    = (position >= POSW'(REG_LO)) && (position < POSW'(REG_HI));
    take_peak = in_reg && (!found_any || (pw > best_power));

    // parabola through the neighbors of the peak
    diff  = $signed({1'b0, pwr_before}) - $signed({1'b0, pwr_after});
    denom = $signed({3'b000, pwr_before}) + $signed({3'b000, pwr_after})
            - $signed({2'b00, best_power, 1'b0});
    interp_ok = found_any && !capture_next
                && (best_position > POSW'(REG_LO))
                && (({1'b0, best_position} + (POSW+1)'(1)) < (POSW+1)'(REG_HI))
                && denom[PWR_W+2];

    // one restoring quotient bit
    div_r2     = {div_r[PWR_W+1:0], 1'b0};
    div_ge     = div_r2 >= {1'b0, div_d};
    div_q_next = {div_q[FRAC_STEPS-2:0], div_ge};

    fine     = (FINEW'(lag_q) <<< 8) + FINEW'(frac_q);
    neg_fine = -((FINEW+1)'(fine));

    mul_next = mul_acc + (ts_sh[0] ? mul_mcand : '0);
    mul_ext  = XW'(mul_acc);
    if (mul_ext > XW'(DT_MAX)) begin
      dt = DT_MAX;
    end else if (mul_ext < XW'(DT_MIN)) begin
      dt = DT_MIN;
    end else begin
      dt = mul_ext[DT_W-1:0];
    end

    out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      time_scale    <= CFG_W'(1);
      m_axis_tvalid <= 1'b0;
      position      <= '0;
      best_position <= '0;
      best_power    <= '0;
      pwr_before    <= '0;
      pwr_after     <= '0;
      prev_power    <= '0;
      capture_next  <= 1'b0;
      found_any     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        time_scale <= cfg_data;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mplr_re  <= mag_re;
            mplr_im  <= mag_im;
            mcand_re <= SQW'(mag_re);
            mcand_im <= SQW'(mag_im);
            sq_acc   <= '0;
            last_q   <= s_axis_tlast;
            cnt      <= '0;
            state    <= S_SQR;
          end
        end
        S_SQR: begin
          sq_acc   <= sq_next;
          mcand_re <= mcand_re << 1;
          mcand_im <= mcand_im << 1;
          mplr_re  <= mplr_re >> 1;
          mplr_im  <= mplr_im >> 1;
          cnt      <= cnt + CNTW'(1);
          if (cnt == CNTW'(SB - 1)) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (position < POSW'(WIN_LEN)) begin
            if (take_peak) begin
              best_power    <= pw;
              best_position <= position;
              pwr_before    <= prev_power;
              capture_next  <= 1'b1;
              found_any     <= 1'b1;
            end else if (capture_next) begin
              pwr_after    <= pw;
              capture_next <= 1'b0;
            end
            prev_power <= pw;
            position   <= position + POSW'(1);
          end
          state <= last_q ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          // an empty search gives lag 0, power 0 and no interpolation
          lag_q    <= found_any ? $signed({1'b0, best_position}) - LAGW'(WINDOW_HALF) : '0;
          peak_q   <= found_any ? best_power : '0;
          interp_q <= interp_ok;
          neg_q    <= !diff[PWR_W] && (diff != '0);
          div_a    <= diff[PWR_W] ? PWR_W'(-diff) : diff[PWR_W-1:0];
          div_d    <= (PWR_W+2)'(-denom);
          position      <= '0;
          best_position <= '0;
          best_power    <= '0;
          pwr_before    <= '0;
          pwr_after     <= '0;
          prev_power    <= '0;
          capture_next  <= 1'b0;
          found_any     <= 1'b0;
          state         <= S_CMP;
        end
        S_CMP: begin
          if (!interp_q) begin
            frac_q <= '0;
            state  <= S_FINE;
          end else if ({2'b00, div_a} >= div_d) begin
            // quotient reaches one half: clamp
            frac_q <= neg_q ? -FRAC_HALF : FRAC_HALF;
            state  <= S_FINE;
          end else begin
            div_r <= {3'b000, div_a};
            div_q <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          div_r <= div_ge ? div_r2 - {1'b0, div_d} : div_r2;
          div_q <= div_q_next;
          cnt   <= cnt + CNTW'(1);
          if (cnt == CNTW'(FRAC_STEPS - 1)) begin
            frac_q <= neg_q ? -$signed({2'b00, div_q_next}) : $signed({2'b00, div_q_next});
            state  <= S_FINE;
          end
        end
        S_FINE: begin
          mul_mcand <= MACCW'(neg_fine);
          mul_acc   <= '0;
          ts_sh     <= time_scale;
          cnt       <= '0;
          state     <= S_MUL;
        end
        S_MUL: begin
          mul_acc   <= mul_next;
          mul_mcand <= mul_mcand <<< 1;
          ts_sh     <= ts_sh >> 1;
          cnt       <= cnt + CNTW'(1);
          if (cnt == CNTW'(MUL_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_axis_tdata <= {{OUT_PAD{1'b0}}, dt, peak_q, frac_q, LAG_W'(lag_q)};
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/cpsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsi_checker
// Port-level checks of the peak search block, bound to its top level.
// ----------------------------------------------------------------------------
module cpsi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cpsi_pkg::OUT_TDW-1:0]  m_axis_tdata
);
  import cpsi_pkg::*;

  logic signed [FRAC_W-1:0] frac_f;
  logic [PWR_W-1:0]         pwr_f;

  assign frac_f = m_axis_tdata[FRAC_LSB +: FRAC_W];
  assign pwr_f  = m_axis_tdata[PWR_LSB +: PWR_W];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // one sample is worked on at a time
  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sample taken while squarer busy");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (frac_f <= 9'sd128) && (frac_f >= -9'sd128))
    else $error("fractional offset beyond one half");

  // a zero peak has a non-negative curvature, so no interpolation
  a_zero_peak: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (pwr_f == '0) |-> (frac_f == '0))
    else $error("offset on a zero peak");

endmodule

bind circular_peak_search_interp cpsi_checker u_cpsi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
